FILE: src/radix_integer_text_parser_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the radix integer text parser core
// Shared property wrappers; clocked on clk_i and disabled during rst_ni low.
// ----------------------------------------------------------------------------
`ifndef RADIX_INTEGER_TEXT_PARSER_CORE_MACROS_SVH
`define RADIX_INTEGER_TEXT_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define RTP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/rtp_pkg.sv
// ----------------------------------------------------------------------------
// rtp_pkg
// Types and constants shared by the radix integer text parser modules.
// ----------------------------------------------------------------------------
package rtp_pkg;

  localparam int OFFSET_BITS = 16;
  // offset counter saturates at 2^CNT_W - 1, never above 16 bits
  localparam int CNT_W       = (OFFSET_BITS >= 16) ? 16 : OFFSET_BITS;
  localparam int OFF_OUT_W   = 16;
  localparam int VALUE_W     = 64;
  localparam int BASE_W      = 6;
  localparam int CHAR_W      = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 8'd1;

  localparam logic [BASE_W-1:0] NUMBER_BASE_RST = 6'd10;
  localparam logic              SIGNED_MODE_RST = 1'b1;

  localparam logic [BASE_W-1:0] BASE_8  = 6'd8;
  localparam logic [BASE_W-1:0] BASE_10 = 6'd10;
  localparam logic [BASE_W-1:0] BASE_16 = 6'd16;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

  typedef struct packed {
    logic              start_of_text;
    logic [CHAR_W-1:0] text_char;
  } in_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   parsed_value;
    logic [OFF_OUT_W-1:0] stop_offset;
    logic [BASE_W-1:0]    base_used;
  } out_item_t;

  typedef struct packed {
    logic [BASE_W-1:0] number_base;
    logic              signed_mode;
  } cfg_t;

endpackage

FILE: src/rtp_engine.sv
// ----------------------------------------------------------------------------
// rtp_engine
// Parse state and one-character next-state logic; flags the stop character.
// ----------------------------------------------------------------------------
`include "radix_integer_text_parser_core_macros.svh"

module rtp_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  rtp_pkg::in_item_t item_i,
  input  rtp_pkg::cfg_t     cfg_i,
  output logic              res_valid_o,
  output rtp_pkg::out_item_t res_o
);
  import rtp_pkg::*;

  localparam int PROD_W = VALUE_W + BASE_W;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    PH_DONE,
    PH_BLANK,
    PH_PREFIX,
    PH_ZERO16,
    PH_ZERO0,
    PH_DIGITS
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic [BASE_W-1:0]  base_q, base_d;
  logic               minus_q, minus_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;

  logic [CHAR_W-1:0]  c;
  logic               is_x;
  logic               dig_hit;
  logic [BASE_W-1:0]  dig;
  logic               consume;
  logic               hold;
  logic               emit;
  logic [PROD_W-1:0]  prod;

  assign c    = item_i.text_char;
  assign is_x = (c == CH_LX) || (c == CH_UX);

  always_comb begin
    dig_hit = 1'b1;
    dig     = '0;
    if (c inside {[CH_0:CH_9]}) begin
      dig = BASE_W'(c - CH_0);
    end else if (c inside {[CH_LA:CH_LZ]}) begin
      dig = BASE_W'(c - CH_LA) + BASE_10;
    end else if (c inside {[CH_UA:CH_UZ]}) begin
      dig = BASE_W'(c - CH_UA) + BASE_10;
    end else begin
      dig_hit = 1'b0;
    end
  end

  // Phases fall through within one character, as in a prefix scanner.
  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    base_d  = base_q;
    minus_d = minus_q;
    cnt_d   = cnt_q;
    consume = 1'b0;
    hold    = 1'b0;
    emit    = 1'b0;
    prod    = '0;

    if (item_i.start_of_text) begin
      phase_d = PH_BLANK;
      acc_d   = '0;
      base_d  = cfg_i.number_base;
      minus_d = 1'b0;
      cnt_d   = '0;
    end

    if (phase_d == PH_BLANK) begin
      if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
        consume = 1'b1;
        hold    = 1'b1;
      end else if (c == CH_MINUS && cfg_i.signed_mode) begin
        minus_d = 1'b1;
        consume = 1'b1;
        hold    = 1'b1;
        phase_d = PH_PREFIX;
      end else if (c == CH_PLUS) begin
        consume = 1'b1;
        hold    = 1'b1;
        phase_d = PH_PREFIX;
      end else begin
        phase_d = PH_PREFIX;
      end
    end

    if (!hold && phase_d == PH_PREFIX) begin
      if (base_d == '0) begin
        if (c == CH_0) begin
          consume = 1'b1;
          hold    = 1'b1;
          phase_d = PH_ZERO0;
        end else begin
          base_d = BASE_10;
        end
      end else if (base_d == BASE_16 && c == CH_0) begin
        consume = 1'b1;
        hold    = 1'b1;
        phase_d = PH_ZERO16;
      end
      if (!hold) begin
        phase_d = PH_DIGITS;
      end
    end

    if (!hold && phase_d == PH_ZERO16) begin
      phase_d = PH_DIGITS;
      if (is_x) begin
        consume = 1'b1;
        hold    = 1'b1;
      end
    end

    if (!hold && phase_d == PH_ZERO0) begin
      phase_d = PH_DIGITS;
      if (is_x) begin
        base_d  = BASE_16;
        consume = 1'b1;
        hold    = 1'b1;
      end else begin
        base_d = BASE_8;
      end
    end

    if (!hold && phase_d == PH_DIGITS) begin
      if (dig_hit && dig < base_d) begin
        prod    = PROD_W'(acc_d) * PROD_W'(base_d);
        acc_d   = prod[VALUE_W-1:0] + VALUE_W'(dig);
        consume = 1'b1;
      end else begin
        emit    = 1'b1;
        phase_d = PH_DONE;
      end
    end

    if (consume && cnt_d != CNT_MAX) begin
      cnt_d = cnt_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      acc_q   <= '0;
      base_q  <= '0;
      minus_q <= 1'b0;
      cnt_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      base_q  <= base_d;
      minus_q <= minus_d;
      cnt_q   <= cnt_d;
    end
  end

  assign res_valid_o        = step_i && emit;
  assign res_o.parsed_value = minus_d ? (VALUE_W'(0) - acc_d) : acc_d;
  assign res_o.stop_offset  = OFF_OUT_W'(cnt_d);
  assign res_o.base_used    = base_d;

  `RTP_ASSERT_NEXT(a_done_after_result, res_valid_o, phase_q == PH_DONE,
    "parser not idle after a result")
  `RTP_ASSERT_IMPL(a_idle_no_result, step_i && !item_i.start_of_text && phase_q == PH_DONE,
    !res_valid_o, "result produced without an open string")
  `RTP_ASSERT_IMPL(a_base_resolved, res_valid_o, res_o.base_used != '0,
    "result carries an unresolved radix")
  `RTP_ASSERT_NEXT(a_hold_when_idle, !step_i, $stable(cnt_q) && $stable(acc_q),
    "parse state changed without a step")

endmodule

FILE: src/rtp_out_reg.sv
// ----------------------------------------------------------------------------
// rtp_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module rtp_out_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  rtp_pkg::out_item_t data_i,
  output logic               free_o,
  output logic               out_valid_o,
  output rtp_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);
  import rtp_pkg::*;

  logic      valid_q;
  out_item_t data_q;

  // slot frees up in the same cycle the pending result transfers
  assign free_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= data_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: src/radix_integer_text_parser_core.sv
// ----------------------------------------------------------------------------
// radix_integer_text_parser_core
// strtol-style integer parser: one character per transfer, one result per string.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_data_i / in_stall_o) carries one character per
//   transfer; start_of_text marks the first character of a string. Output channel
//   (out_valid_o / out_data_o / out_stall_i) carries one result per string, on
//   the first character that does not parse.
//   Configuration (cfg_valid_i / cfg_ready_o, index 0 = number_base,
//   index 1 = signed_mode) is always ready; write only while idle.
// Timing:
//   A character goes into the input register on transfer and is parsed once the
//   output register is free; its result is then registered in the output
//   register. Throughput is one character per cycle while the output is not
//   stalled, bounded by the 64x6 multiply-add in the parse step.
// Reset: no string open, number_base = 10, signed_mode = 1, output empty.
// Stall: a stalled result holds the output register; the input register then
//   holds its character and in_stall_o rises until the result transfers.
// ----------------------------------------------------------------------------
module radix_integer_text_parser_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  rtp_pkg::in_item_t                 in_data_i,
  output logic                              in_stall_o,
  output logic                              out_valid_o,
  output rtp_pkg::out_item_t                out_data_o,
  input  logic                              out_stall_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rtp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [rtp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import rtp_pkg::*;

  cfg_t      cfg_q;
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  logic      out_free;
  logic      step;
  logic      in_xfer;
  logic      res_valid;
  out_item_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.number_base <= NUMBER_BASE_RST;
      cfg_q.signed_mode <= SIGNED_MODE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_NUMBER_BASE) begin
        cfg_q.number_base <= cfg_data_i[BASE_W-1:0];
      end
      if (cfg_index_i == REG_SIGNED_MODE) begin
        cfg_q.signed_mode <= cfg_data_i[0];
      end
    end
  end

  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (step) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q <= in_data_i;
    end
  end

  rtp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (s1_item_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  rtp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .data_i      (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
